// ----- sv/fp_multiplier_e8m14_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the fp multiplier
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FP_MULTIPLIER_E8M14_ASSERT_SVH
`define FP_MULTIPLIER_E8M14_ASSERT_SVH

// assert a property under clock and active-low reset
`define FPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// assert a property that must also hold while reset is low
`define FPM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- sv/fpm_pkg.sv -----
// ----------------------------------------------------------------------------
// fpm_pkg
// Constants and class codes for the class-tagged floating-point multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package fpm_pkg;

  localparam int unsigned ExpBitsDefault  = 8;
  localparam int unsigned FracBitsDefault = 14;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_NORM = 2'd1,
    CLS_INF  = 2'd2,
    CLS_NAN  = 2'd3
  } fpm_cls_e;

endpackage

`default_nettype wire

// ----- sv/fpm_core.sv -----
// ----------------------------------------------------------------------------
// fpm_core
// Combinational multiply, normalize, round-to-nearest-even and class mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module fpm_core import fpm_pkg::*; #(
  parameter int unsigned EXP_BITS  = ExpBitsDefault,
  parameter int unsigned FRAC_BITS = FracBitsDefault,
  localparam int unsigned W = EXP_BITS + FRAC_BITS + 3
) (
  input  wire logic [W-1:0] x_i,
  input  wire logic [W-1:0] y_i,
  output logic      [W-1:0] p_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned E  = EXP_BITS;
  localparam int unsigned EW = E + 2;
  localparam logic [EW-1:0] Bias = EW'((1 << (E - 1)) - 1);
  localparam logic [EW-1:0] EMax = EW'((1 << E) - 1);

  fpm_cls_e cx, cy, cls;
  logic sign;
  logic [E-1:0] ex, ey;
  logic [F:0] sx, sy;
  logic [2*F+1:0] prod;
  logic norm, guard, sticky, up;
  logic [F-1:0] frac, frac_r;
  logic [F:0] frac_inc;
  logic [EW-1:0] e_val;

  always_comb begin
    cx   = fpm_cls_e'(x_i[W-1 -: 2]);
    cy   = fpm_cls_e'(y_i[W-1 -: 2]);
    sign = x_i[E+F] ^ y_i[E+F];
    ex   = x_i[F +: E];
    ey   = y_i[F +: E];
    sx   = {1'b1, x_i[F-1:0]};
    sy   = {1'b1, y_i[F-1:0]};
    prod = (2*F+2)'(sx) * (2*F+2)'(sy);
    norm = prod[2*F+1];
    if (norm) begin
      frac   = prod[F+1 +: F];
      guard  = prod[F];
      sticky = |prod[F-1:0];
    end else begin
      frac   = prod[F +: F];
      guard  = prod[F-1];
      sticky = |prod[F-2:0];
    end
    up       = guard & (sticky | frac[0]);
    frac_inc = {1'b0, frac} + (F+1)'(up);
    frac_r   = frac_inc[F-1:0];
    e_val    = EW'(ex) + EW'(ey) - Bias + EW'(norm) + EW'(frac_inc[F]);

    if (cx == CLS_NAN || cy == CLS_NAN) cls = CLS_NAN;
    else if ((cx == CLS_ZERO && cy == CLS_INF) || (cx == CLS_INF && cy == CLS_ZERO))
      cls = CLS_NAN;
    else if (cx == CLS_ZERO || cy == CLS_ZERO) cls = CLS_ZERO;
    else if (cx == CLS_INF || cy == CLS_INF) cls = CLS_INF;
    else if (e_val[EW-1]) cls = CLS_ZERO;
    else if (e_val >= EMax) cls = CLS_INF;
    else if (e_val == '0) cls = CLS_ZERO;
    else cls = CLS_NORM;

    unique case (cls)
      CLS_NORM: p_o = {CLS_NORM, sign, e_val[E-1:0], frac_r};
      CLS_INF:  p_o = {CLS_INF, sign, EMax[E-1:0], {F{1'b0}}};
      CLS_NAN:  p_o = {CLS_NAN, sign, EMax[E-1:0], F'(1)};
      default:  p_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/fp_multiplier_e8m14.sv -----
// A beat passes through the input register and then the result register.
// One beat per cycle unless the output stalls; single-pass multiply/round path.
// The result register holds a stalled beat while a new one is taken into the
// input register. Reset clears both valid flags; payload is not reset.
// ----------------------------------------------------------------------------
// fp_multiplier_e8m14
// Streaming class-tagged floating-point multiplier, round to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none

module fp_multiplier_e8m14 import fpm_pkg::*; #(
  parameter int unsigned EXP_BITS  = ExpBitsDefault,
  parameter int unsigned FRAC_BITS = FracBitsDefault,
  localparam int unsigned W  = EXP_BITS + FRAC_BITS + 3,
  localparam int unsigned IB = ((2*W + 7) / 8) * 8,
  localparam int unsigned OB = ((W + 7) / 8) * 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [IB-1:0] s_axis_tdata,  // x_operand, y_operand
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic      [OB-1:0] m_axis_tdata   // product
);

  logic in_vld_q;
  logic [W-1:0] x_q, y_q, p_d, p_q;
  logic out_vld_q;
  logic adv;

  assign adv           = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (adv) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      x_q <= s_axis_tdata[W-1:0];
      y_q <= s_axis_tdata[2*W-1:W];
    end
    if (adv) p_q <= p_d;
  end

  fpm_core #(.EXP_BITS(EXP_BITS), .FRAC_BITS(FRAC_BITS)) u_core (
    .x_i(x_q),
    .y_i(y_q),
    .p_o(p_d)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OB'(p_q);

endmodule

`default_nettype wire

// ----- sv/fp_multiplier_e8m14_chk.sv -----
// ----------------------------------------------------------------------------
// fp_multiplier_e8m14_chk
// Port-level checker bound to the multiplier top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fp_multiplier_e8m14_assert.svh"

module fp_multiplier_e8m14_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  `FPM_ASSERT_RST(a_rst_quiet, !rst_ni |=> !m_axis_tvalid, "product beat after reset")
  `FPM_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")
  `FPM_ASSERT(a_pad, m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0, "pad bits set")
  `FPM_ASSERT(a_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
  `FPM_ASSERT(a_beat, s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid, "beat lost")

endmodule

bind fp_multiplier_e8m14 fp_multiplier_e8m14_chk u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

`default_nettype wire
